@@ src/lsa_pkg.sv @@
// Package for the lidar sector average block: widths, codes, state and
// control types shared by the config, controller and datapath modules.
// Depends on nothing.
package lsa_pkg;

  localparam int unsigned IDX_W      = 13;
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned NUM_SECT   = 3;
  localparam int unsigned SECT_W     = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned BIT_CNT_W  = 5;
  localparam int unsigned MAX_SCAN   = 4096;
  localparam int unsigned OUT_DATA_W = NUM_SECT * RANGE_W;
  localparam int unsigned OUT_USER_W = NUM_SECT * STAT_W;

  localparam logic [IDX_W-1:0]     MAX_SCAN_POS = IDX_W'(MAX_SCAN);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT     = BIT_CNT_W'(SUM_W - 1);
  localparam logic [SECT_W-1:0]    LAST_SECT    = SECT_W'(NUM_SECT - 1);
  localparam logic [RANGE_W-1:0]   MAX_RANGE_RST = '1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_VALID = 2'd1,
    STAT_EMPTY    = 2'd2
  } sect_stat_t;

  typedef enum logic [2:0] {
    REG_FRONT_FIRST = 3'd0,
    REG_FRONT_END   = 3'd1,
    REG_LEFT_FIRST  = 3'd2,
    REG_LEFT_END    = 3'd3,
    REG_RIGHT_FIRST = 3'd4,
    REG_RIGHT_END   = 3'd5,
    REG_MIN_RANGE   = 3'd6,
    REG_MAX_RANGE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [NUM_SECT-1:0][IDX_W-1:0] first_idx;
    logic [NUM_SECT-1:0][IDX_W-1:0] end_idx;
    logic [RANGE_W-1:0]             min_range;
    logic [RANGE_W-1:0]             max_range;
  } cfg_t;

  typedef struct packed {
    logic accum;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/lsa_cfg.sv @@
// Configuration register file of the lidar sector average block.
// APB-style write/read port; uses lsa_pkg.
module lsa_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lsa_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lsa_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lsa_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output lsa_pkg::cfg_t                cfg
);

  lsa_pkg::cfg_t     cfg_r;
  lsa_pkg::cfg_t     cfg_nxt;
  lsa_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = lsa_pkg::reg_idx_t'(cfg_paddr[lsa_pkg::ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lsa_pkg::REG_FRONT_FIRST: cfg_nxt.first_idx[0] = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_FRONT_END:   cfg_nxt.end_idx[0]   = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_LEFT_FIRST:  cfg_nxt.first_idx[1] = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_LEFT_END:    cfg_nxt.end_idx[1]   = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_RIGHT_FIRST: cfg_nxt.first_idx[2] = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_RIGHT_END:   cfg_nxt.end_idx[2]   = cfg_pwdata[lsa_pkg::IDX_W-1:0];
        lsa_pkg::REG_MIN_RANGE:   cfg_nxt.min_range    = cfg_pwdata[lsa_pkg::RANGE_W-1:0];
        lsa_pkg::REG_MAX_RANGE:   cfg_nxt.max_range    = cfg_pwdata[lsa_pkg::RANGE_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lsa_pkg::REG_FRONT_FIRST: cfg_prdata = lsa_pkg::DATA_W'(cfg_r.first_idx[0]);
      lsa_pkg::REG_FRONT_END:   cfg_prdata = lsa_pkg::DATA_W'(cfg_r.end_idx[0]);
      lsa_pkg::REG_LEFT_FIRST:  cfg_prdata = lsa_pkg::DATA_W'(cfg_r.first_idx[1]);
      lsa_pkg::REG_LEFT_END:    cfg_prdata = lsa_pkg::DATA_W'(cfg_r.end_idx[1]);
      lsa_pkg::REG_RIGHT_FIRST: cfg_prdata = lsa_pkg::DATA_W'(cfg_r.first_idx[2]);
      lsa_pkg::REG_RIGHT_END:   cfg_prdata = lsa_pkg::DATA_W'(cfg_r.end_idx[2]);
      lsa_pkg::REG_MIN_RANGE:   cfg_prdata = lsa_pkg::DATA_W'(cfg_r.min_range);
      lsa_pkg::REG_MAX_RANGE:   cfg_prdata = lsa_pkg::DATA_W'(cfg_r.max_range);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_idx <= '0;
      cfg_r.end_idx   <= '0;
      cfg_r.min_range <= '0;
      cfg_r.max_range <= lsa_pkg::MAX_RANGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/lsa_ctrl.sv @@
// Controller of the lidar sector average block: scan accumulation,
// divider sequencing and result hand-off. Uses lsa_pkg.
module lsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  input  lsa_pkg::dp_stat_t  stat,
  output lsa_pkg::ctrl_cmd_t cmd
);

  lsa_pkg::ctrl_state_t state_r;
  lsa_pkg::ctrl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsa_pkg::ST_ACCUM: if (in_tvalid && in_tlast) state_nxt = lsa_pkg::ST_LOAD;
      lsa_pkg::ST_LOAD:  state_nxt = lsa_pkg::ST_DIV;
      lsa_pkg::ST_DIV:   if (stat.div_done) state_nxt = lsa_pkg::ST_OUT;
      lsa_pkg::ST_OUT:   if (stat.out_free) state_nxt = lsa_pkg::ST_ACCUM;
      default:           state_nxt = lsa_pkg::ST_ACCUM;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      lsa_pkg::ST_ACCUM: begin
        in_tready = 1'b1;
        cmd.accum = in_tvalid;
      end
      lsa_pkg::ST_LOAD: cmd.div_load = 1'b1;
      lsa_pkg::ST_DIV:  cmd.div_step = 1'b1;
      lsa_pkg::ST_OUT:  cmd.out_load = stat.out_free;
      default:          cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsa_pkg::ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/lsa_dp.sv @@
// Datapath of the lidar sector average block: sample position, sector
// accumulators, shared restoring divider and output register. Uses lsa_pkg.
module lsa_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsa_pkg::cfg_t                    cfg,
  input  lsa_pkg::ctrl_cmd_t               cmd,
  output lsa_pkg::dp_stat_t                stat,
  input  logic [lsa_pkg::RANGE_W-1:0]      in_range,
  input  logic                             in_finite,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lsa_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [lsa_pkg::OUT_USER_W-1:0]   out_tuser
);

  logic [lsa_pkg::IDX_W-1:0]                         pos_r;
  logic [lsa_pkg::NUM_SECT-1:0][lsa_pkg::SUM_W-1:0]  sum_r;
  logic [lsa_pkg::NUM_SECT-1:0][lsa_pkg::CNT_W-1:0]  cnt_r;
  logic [lsa_pkg::NUM_SECT-1:0]                      seen_r;
  logic [lsa_pkg::NUM_SECT-1:0][lsa_pkg::RANGE_W-1:0] quo_r;

  logic [lsa_pkg::SECT_W-1:0]    sel_r;
  logic [lsa_pkg::BIT_CNT_W-1:0] bit_r;
  logic [lsa_pkg::SUM_W-1:0]     q_r;
  logic [lsa_pkg::CNT_W-1:0]     rem_r;
  logic [lsa_pkg::CNT_W-1:0]     div_r;

  logic                          out_valid_r;
  logic [lsa_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [lsa_pkg::OUT_USER_W-1:0] out_user_r;

  logic                          in_scan;
  logic                          sample_ok;
  logic [lsa_pkg::NUM_SECT-1:0]  in_win;
  logic [lsa_pkg::CNT_W:0]       rem_sh;
  logic                          rem_ge;
  logic [lsa_pkg::CNT_W-1:0]     rem_nxt;
  logic [lsa_pkg::SUM_W-1:0]     q_nxt;
  logic                          bit_last;
  logic [lsa_pkg::SECT_W-1:0]    sel_nxt;
  logic [lsa_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic [lsa_pkg::OUT_USER_W-1:0] out_user_nxt;

  assign in_scan   = pos_r < lsa_pkg::MAX_SCAN_POS;
  assign sample_ok = in_finite && (in_range >= cfg.min_range) && (in_range <= cfg.max_range);

  always_comb begin
    for (int s = 0; s < lsa_pkg::NUM_SECT; s++) begin
      in_win[s] = in_scan && (pos_r >= cfg.first_idx[s]) && (pos_r < cfg.end_idx[s]);
    end
  end

  assign rem_sh   = {rem_r, q_r[lsa_pkg::SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_r};
  assign rem_nxt  = rem_ge ? lsa_pkg::CNT_W'(rem_sh - {1'b0, div_r})
                           : lsa_pkg::CNT_W'(rem_sh);
  assign q_nxt    = {q_r[lsa_pkg::SUM_W-2:0], rem_ge};
  assign bit_last = bit_r == lsa_pkg::LAST_BIT;
  assign sel_nxt  = sel_r + 1'b1;

  assign stat.div_done = cmd.div_step && bit_last && (sel_r == lsa_pkg::LAST_SECT);
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    for (int s = 0; s < lsa_pkg::NUM_SECT; s++) begin
      if (!seen_r[s]) begin
        out_data_nxt[s*lsa_pkg::RANGE_W +: lsa_pkg::RANGE_W] = '0;
        out_user_nxt[s*lsa_pkg::STAT_W +: lsa_pkg::STAT_W]   = lsa_pkg::STAT_EMPTY;
      end else if (cnt_r[s] == '0) begin
        out_data_nxt[s*lsa_pkg::RANGE_W +: lsa_pkg::RANGE_W] = cfg.max_range;
        out_user_nxt[s*lsa_pkg::STAT_W +: lsa_pkg::STAT_W]   = lsa_pkg::STAT_NO_VALID;
      end else begin
        out_data_nxt[s*lsa_pkg::RANGE_W +: lsa_pkg::RANGE_W] = quo_r[s];
        out_user_nxt[s*lsa_pkg::STAT_W +: lsa_pkg::STAT_W]   = lsa_pkg::STAT_OK;
      end
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      pos_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      seen_r <= '0;
    end else if (cmd.accum) begin
      if (in_scan) begin
        pos_r <= pos_r + 1'b1;
      end
      for (int s = 0; s < lsa_pkg::NUM_SECT; s++) begin
        if (in_win[s]) begin
          seen_r[s] <= 1'b1;
          if (sample_ok) begin
            sum_r[s] <= sum_r[s] + lsa_pkg::SUM_W'(in_range);
            cnt_r[s] <= cnt_r[s] + 1'b1;
          end
        end
      end
    end
  end

  // shared divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
      bit_r <= '0;
    end else if (cmd.div_load) begin
      sel_r <= '0;
      bit_r <= '0;
    end else if (cmd.div_step) begin
      if (bit_last) begin
        bit_r <= '0;
        sel_r <= sel_nxt;
      end else begin
        bit_r <= bit_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r   <= sum_r[0];
      div_r <= cnt_r[0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (bit_last) begin
        quo_r[sel_r] <= q_nxt[lsa_pkg::RANGE_W-1:0];
        rem_r        <= '0;
        if (sel_r != lsa_pkg::LAST_SECT) begin
          q_r   <= sum_r[sel_nxt];
          div_r <= cnt_r[sel_nxt];
        end
      end else begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ src/lidar_sector_average.sv @@
// Lidar sector average: mean range of three index windows of a laser scan.
// After the last-of-scan sample is accepted the result is formed by a load,
// 3 x 28 steps of the shared bit-serial divider and an output load.
// Throughput: one sample per cycle within a scan; input stalls after each last
// sample while the divider runs, longer if the previous result is not taken.
// Reset: synchronous active low; clears scan state, registers to defaults.
module lidar_sector_average (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lsa_pkg::RANGE_W-1:0]    in_tdata,   // [15:0] range_sample
  input  logic                           in_tuser,   // [0] sample_finite
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] front_mean, [31:16] left_mean, [47:32] right_mean
  output logic [lsa_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] front_status, [3:2] left_status, [5:4] right_status
  output logic [lsa_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lsa_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [lsa_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [lsa_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                           cfg_pready
);

  lsa_pkg::cfg_t      cfg;
  lsa_pkg::ctrl_cmd_t cmd;
  lsa_pkg::dp_stat_t  stat;

  lsa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_range   (in_tdata),
    .in_finite  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
